// ===== rtl/core/tws_pkg.sv =====
// ---------------------------------------------------------------------------
// tws_pkg
// Shared types and constants of the timed register write sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  // request codes
  localparam logic [2:0] REQ_LOAD    = 3'd0;
  localparam logic [2:0] REQ_START   = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_TICK    = 3'd3;
  localparam logic [2:0] REQ_SILENCE = 3'd4;

  // configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] CFG_SHORT_DELAY = 3'd0;
  localparam logic [2:0] CFG_LONG_DELAY  = 3'd1;
  localparam logic [2:0] CFG_TABLE_LEN   = 3'd2;
  localparam logic [2:0] CFG_SONG_LEN    = 3'd3;
  localparam logic [2:0] CFG_LOOP        = 3'd4;
  localparam logic [2:0] CFG_KEY_REPORT  = 3'd5;

  localparam int CFG_ADDR_W = 5;
  localparam int LEN_W      = 15;
  localparam int POS_W      = 16;

  // chip register numbers
  localparam logic [7:0] KEY_LO      = 8'hB0;
  localparam logic [7:0] KEY_HI      = 8'hB8;
  localparam logic [7:0] RHYTHM_REG  = 8'hBD;
  localparam int         KEY_CHANS   = 9;
  localparam int         SIL_WRITES  = 2 * KEY_CHANS + 1;
  localparam int         SIL_CNT_W   = 5;

  typedef struct packed {
    logic [7:0]       short_delay_code;
    logic [7:0]       long_delay_code;
    logic [LEN_W-1:0] code_table_length;
    logic [LEN_W-1:0] song_length;
    logic             loop_enable;
    logic             key_report_enable;
  } cfg_t;

  typedef struct packed {
    logic [8:0] reg_address;
    logic [7:0] reg_value;
    logic       key_valid;
    logic [4:0] key_code;
    logic       is_playing;
    logic       last_write;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/tws_in_if.sv =====
// ---------------------------------------------------------------------------
// tws_in_if
// Request channel: valid/ready handshake with the request payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface tws_in_if;
  import tws_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [13:0] load_address;
  logic [7:0]  load_byte;
  logic [15:0] elapsed_ms;

  modport source (output valid, output req_type, output load_address,
                  output load_byte, output elapsed_ms, input ready);
  modport sink   (input valid, input req_type, input load_address,
                  input load_byte, input elapsed_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tws_out_if.sv =====
// ---------------------------------------------------------------------------
// tws_out_if
// Result channel: valid/ready handshake carrying one register write.
// ---------------------------------------------------------------------------
`default_nettype none

interface tws_out_if;
  import tws_pkg::*;

  logic       valid;
  logic       ready;
  logic [8:0] reg_address;
  logic [7:0] reg_value;
  logic       key_valid;
  logic [4:0] key_code;
  logic       is_playing;
  logic       last_write;

  modport source (output valid, output reg_address, output reg_value,
                  output key_valid, output key_code, output is_playing,
                  output last_write, input ready);
  modport sink   (input valid, input reg_address, input reg_value,
                  input key_valid, input key_code, input is_playing,
                  input last_write, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tws_ram.sv =====
// ---------------------------------------------------------------------------
// tws_ram
// Generic simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // data holds while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/tws_cfg.sv =====
// ---------------------------------------------------------------------------
// tws_cfg
// APB-style configuration register file of the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module tws_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tws_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output tws_pkg::cfg_t                       cfg
);
  import tws_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        CFG_SHORT_DELAY: cfg_nxt.short_delay_code  = pwdata[7:0];
        CFG_LONG_DELAY:  cfg_nxt.long_delay_code   = pwdata[7:0];
        CFG_TABLE_LEN:   cfg_nxt.code_table_length = pwdata[LEN_W-1:0];
        CFG_SONG_LEN:    cfg_nxt.song_length       = pwdata[LEN_W-1:0];
        CFG_LOOP:        cfg_nxt.loop_enable       = pwdata[0];
        CFG_KEY_REPORT:  cfg_nxt.key_report_enable = pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      CFG_SHORT_DELAY: prdata = {24'd0, cfg_r.short_delay_code};
      CFG_LONG_DELAY:  prdata = {24'd0, cfg_r.long_delay_code};
      CFG_TABLE_LEN:   prdata = {17'd0, cfg_r.code_table_length};
      CFG_SONG_LEN:    prdata = {17'd0, cfg_r.song_length};
      CFG_LOOP:        prdata = {31'd0, cfg_r.loop_enable};
      CFG_KEY_REPORT:  prdata = {31'd0, cfg_r.key_report_enable};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/timed_register_write_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// timed_register_write_sequencer_core
// Plays a song held in byte memory as timed chip register writes.
// ---------------------------------------------------------------------------
// Load, start and stop requests are completed in the idle state. A tick walks
// the event stream through the single read port of the song RAM: a delay pair
// passes through the check, code read and value read states and a register
// write pair also through the code table lookup, and a tick emits at most
// MAX_WRITES_PER_TICK writes. The last write of a tick is held back one event
// so it can be flagged as last. A silence request sends its 19 key-off writes
// at one per cycle while out_ch is not stalled. The song RAM needs no clearing
// after reset; locations must be loaded before the stream reads them.
`default_nettype none

module timed_register_write_sequencer_core #(
  parameter int SONG_BYTES          = 16384,
  parameter int MAX_WRITES_PER_TICK = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tws_in_if.sink                              in_ch,
  tws_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tws_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import tws_pkg::*;

  localparam int AW       = $clog2(SONG_BYTES);
  localparam int CW       = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int STEP_CAP = 2 * MAX_WRITES_PER_TICK;
  localparam int SCW      = $clog2(STEP_CAP + 1);
  localparam int WCW      = $clog2(MAX_WRITES_PER_TICK + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_CODE  = 7'b0000100,
    S_VAL   = 7'b0001000,
    S_REG   = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_SIL   = 7'b1000000
  } state_t;

  cfg_t cfg;

  tws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t               state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic signed [31:0]   due_r, due_nxt;
  logic                 play_r, play_nxt;
  logic [SCW-1:0]       steps_r, steps_nxt;
  logic [WCW-1:0]       nw_r, nw_nxt;
  logic [SIL_CNT_W-1:0] sil_r, sil_nxt;
  logic [7:0]           code_r, code_nxt;
  logic [7:0]           val_r, val_nxt;
  logic                 oob_r, oob_nxt;
  res_t                 pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  res_t                 out_r, out_nxt;
  logic                 out_v_r, out_v_nxt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [7:0]           ram_rdata, rd_byte;

  logic                 in_fire, out_free;
  logic signed [32:0]   due_sub;
  logic                 due_pos;
  logic [31:0]          dly_short;
  logic [POS_W-1:0]     pos_inc;
  res_t                 new_w, sil_w;
  logic [7:0]           reg_low;

  tws_ram #(.WIDTH(8), .DEPTH(SONG_BYTES)) u_song_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.load_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_v_r || out_ch.ready;
  assign rd_byte     = oob_r ? 8'd0 : ram_rdata;

  assign due_sub   = {due_r[31], due_r} - $signed({17'd0, in_ch.elapsed_ms});
  assign due_pos   = !due_r[31] && (due_r != 32'sd0);
  assign dly_short = {24'd0, rd_byte} + 32'd1;
  assign pos_inc   = pos_r + POS_W'(1);

  assign ram_waddr = AW'(CW'(in_ch.load_address));

  // register write built from the table byte just read
  assign reg_low = rd_byte;
  always_comb begin
    new_w             = '0;
    new_w.reg_address = {code_r[7], reg_low};
    new_w.reg_value   = val_r;
    new_w.key_valid   = cfg.key_report_enable && (reg_low inside {[KEY_LO:KEY_HI]});
    new_w.key_code    = new_w.key_valid ? val_r[4:0] : 5'd0;
    new_w.is_playing  = 1'b1;
    new_w.last_write  = 1'b0;
  end

  // key-off write for silence slot sil_r
  always_comb begin
    sil_w            = '0;
    sil_w.is_playing = play_r;
    sil_w.last_write = (sil_r == SIL_CNT_W'(SIL_WRITES - 1));
    if (sil_r < SIL_CNT_W'(KEY_CHANS)) begin
      sil_w.reg_address = {1'b0, 8'(KEY_LO + {3'd0, sil_r})};
    end else if (sil_r < SIL_CNT_W'(2 * KEY_CHANS)) begin
      sil_w.reg_address = {1'b1, 8'(KEY_LO + {3'd0, sil_r} - 8'(KEY_CHANS))};
    end else begin
      sil_w.reg_address = {1'b0, RHYTHM_REG};
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    due_nxt    = due_r;
    play_nxt   = play_r;
    steps_nxt  = steps_r;
    nw_nxt     = nw_r;
    sil_nxt    = sil_r;
    code_nxt   = code_r;
    val_nxt    = val_r;
    oob_nxt    = oob_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_ch.ready ? 1'b0 : out_v_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = AW'(CW'(pos_r));

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            REQ_LOAD: begin
              ram_we = CW'(in_ch.load_address) < CW'(SONG_BYTES);
            end
            REQ_START: begin
              pos_nxt  = POS_W'(cfg.code_table_length);
              due_nxt  = 32'sd0;
              play_nxt = cfg.song_length > cfg.code_table_length;
            end
            REQ_STOP: begin
              play_nxt = 1'b0;
            end
            REQ_TICK: begin
              if (play_r) begin
                due_nxt   = (due_sub[32] != due_sub[31]) ? 32'sh8000_0000 : due_sub[31:0];
                steps_nxt = '0;
                nw_nxt    = '0;
                state_nxt = S_CHECK;
              end
            end
            REQ_SILENCE: begin
              sil_nxt   = '0;
              state_nxt = S_SIL;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_CHECK: begin
        if (due_pos || (steps_r == SCW'(STEP_CAP))
            || (nw_r == WCW'(MAX_WRITES_PER_TICK))) begin
          state_nxt = S_FLUSH;
        end else begin
          steps_nxt = steps_r + SCW'(1);
          if (pos_r >= POS_W'(cfg.song_length)) begin
            if (cfg.loop_enable) begin
              pos_nxt = POS_W'(cfg.code_table_length);
              due_nxt = 32'sd0;
            end else begin
              play_nxt  = 1'b0;
              state_nxt = S_FLUSH;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(CW'(pos_r));
            oob_nxt   = CW'(pos_r) >= CW'(SONG_BYTES);
            state_nxt = S_CODE;
          end
        end
      end

      S_CODE: begin
        code_nxt  = rd_byte;
        ram_re    = 1'b1;
        ram_raddr = AW'(CW'(pos_inc));
        oob_nxt   = CW'(pos_inc) >= CW'(SONG_BYTES);
        state_nxt = S_VAL;
      end

      S_VAL: begin
        val_nxt = rd_byte;
        pos_nxt = pos_r + POS_W'(2);
        // short delay code takes priority when both codes match
        if (code_r == cfg.short_delay_code) begin
          due_nxt   = due_r + $signed(dly_short);
          state_nxt = S_CHECK;
        end else if (code_r == cfg.long_delay_code) begin
          due_nxt   = due_r + $signed(dly_short << 8);
          state_nxt = S_CHECK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(code_r[6:0]);
          oob_nxt   = 1'b0;
          state_nxt = S_REG;
        end
      end

      S_REG: begin
        // ram data holds while waiting, no read is issued here
        if (!pend_v_r) begin
          pend_nxt   = new_w;
          pend_v_nxt = 1'b1;
          nw_nxt     = nw_r + WCW'(1);
          state_nxt  = S_CHECK;
        end else if (out_free) begin
          out_nxt    = pend_r;
          out_v_nxt  = 1'b1;
          pend_nxt   = new_w;
          nw_nxt     = nw_r + WCW'(1);
          state_nxt  = S_CHECK;
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt            = pend_r;
          out_nxt.last_write = 1'b1;
          out_v_nxt          = 1'b1;
          pend_v_nxt         = 1'b0;
          state_nxt          = S_IDLE;
        end
      end

      S_SIL: begin
        if (out_free) begin
          out_nxt   = sil_w;
          out_v_nxt = 1'b1;
          sil_nxt   = sil_r + SIL_CNT_W'(1);
          if (sil_r == SIL_CNT_W'(SIL_WRITES - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      due_r    <= '0;
      play_r   <= 1'b0;
      steps_r  <= '0;
      nw_r     <= '0;
      sil_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      oob_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      due_r    <= due_nxt;
      play_r   <= play_nxt;
      steps_r  <= steps_nxt;
      nw_r     <= nw_nxt;
      sil_r    <= sil_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      oob_r    <= oob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    val_r  <= val_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.reg_address = out_r.reg_address;
  assign out_ch.reg_value   = out_r.reg_value;
  assign out_ch.key_valid   = out_r.key_valid;
  assign out_ch.key_code    = out_r.key_code;
  assign out_ch.is_playing  = out_r.is_playing;
  assign out_ch.last_write  = out_r.last_write;

  // a held-back write never survives into a new transaction
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pend_v_r)
    else $error("pending write left over when idle");

  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= SCW'(STEP_CAP))
    else $error("step counter past its cap");

  a_write_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nw_r <= WCW'(MAX_WRITES_PER_TICK))
    else $error("write counter past its cap");

  a_sil_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIL) |-> (sil_r < SIL_CNT_W'(SIL_WRITES)))
    else $error("silence index out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_nxt && !out_v_r && out_nxt.last_write && (state_r == S_FLUSH))
      |=> (state_r == S_IDLE))
    else $error("last write sent but walk not finished");

endmodule

`default_nettype wire

// ===== verif/tws_song_check_pkg.sv =====
// ---------------------------------------------------------------------------
// tws_song_check_pkg
// Scoreboard for the register write sequencer: keeps its own copy of the song
// memory, playback state and settings, predicts the writes of every accepted
// request and checks the writes that come out of the block in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tws_song_check_pkg;
  import tws_pkg::*;

  localparam int     MEM_BYTES       = 16384;
  localparam int     WRITES_PER_TICK = 64;
  localparam int     TABLE_SPAN      = 128;
  localparam longint DUE_FLOOR       = -64'sd2147483648;

  class song_scoreboard;
    // settings
    logic [7:0]  short_dly  = '0;
    logic [7:0]  long_dly   = '0;
    int unsigned table_len  = 0;
    int unsigned song_len   = 0;
    bit          loop_en    = 0;
    bit          key_en     = 0;

    // playback state
    logic [7:0]  song_mem [MEM_BYTES];
    bit          loaded   [MEM_BYTES];
    int unsigned rd_pos   = 0;
    longint      due_ms   = 0;
    bit          playing  = 0;

    res_t        pending [$];
    int unsigned n_items       = 0;
    int unsigned n_ticks       = 0;
    int unsigned n_writes      = 0;
    int unsigned n_key_reports = 0;
    int unsigned n_errors      = 0;

    function logic [7:0] mem_byte(int unsigned a);
      return (a < MEM_BYTES) ? song_mem[a] : 8'h00;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_SHORT_DELAY: short_dly  = val[7:0];
        CFG_LONG_DELAY:  long_dly   = val[7:0];
        CFG_TABLE_LEN:   table_len  = val[LEN_W-1:0];
        CFG_SONG_LEN:    song_len   = val[LEN_W-1:0];
        CFG_LOOP:        loop_en    = val[0];
        CFG_KEY_REPORT:  key_en     = val[0];
        default: ;
      endcase
    endfunction

    // updates the state for one accepted request and queues its writes
    function void note_request(logic [2:0] req, logic [13:0] addr, logic [7:0] data,
                               logic [15:0] ms);
      res_t       batch [$];
      res_t       w;
      logic [7:0] code;
      logic [7:0] val;
      logic [7:0] low;
      int         steps;
      bit         walking;
      n_items++;
      case (req)
        REQ_LOAD: begin
          song_mem[addr] = data;
          loaded[addr]   = 1'b1;
        end
        REQ_START: begin
          rd_pos  = table_len;
          due_ms  = 0;
          playing = song_len > table_len;
        end
        REQ_STOP: playing = 1'b0;
        REQ_TICK: begin
          n_ticks++;
          if (playing) begin
            due_ms -= longint'(ms);
            if (due_ms < DUE_FLOOR) due_ms = DUE_FLOOR;
            steps   = 0;
            walking = 1'b1;
            while (walking && due_ms <= 0 && steps < 2 * WRITES_PER_TICK &&
                   batch.size() < WRITES_PER_TICK) begin
              steps++;
              if (rd_pos >= song_len) begin
                if (loop_en) begin
                  rd_pos = table_len;
                  due_ms = 0;
                end else begin
                  playing = 1'b0;
                  walking = 1'b0;
                end
              end else begin
                code   = mem_byte(rd_pos);
                val    = mem_byte(rd_pos + 1);
                rd_pos += 2;
                // short delay wins when both codes are the same
                if (code == short_dly) begin
                  due_ms += longint'(val) + 1;
                end else if (code == long_dly) begin
                  due_ms += (longint'(val) + 1) * 256;
                end else begin
                  w             = '0;
                  w.reg_address = {code[7], mem_byte(code[6:0])};
                  w.reg_value   = val;
                  low           = w.reg_address[7:0];
                  w.key_valid   = key_en && low >= KEY_LO && low <= KEY_HI;
                  w.key_code    = w.key_valid ? val[4:0] : 5'd0;
                  w.is_playing  = 1'b1;
                  batch.push_back(w);
                end
              end
            end
          end
        end
        REQ_SILENCE: begin
          for (int i = 0; i < SIL_WRITES; i++) begin
            w = '0;
            if (i < KEY_CHANS)
              w.reg_address = {1'b0, 8'(KEY_LO + i)};
            else if (i < 2 * KEY_CHANS)
              w.reg_address = {1'b1, 8'(KEY_LO + i - KEY_CHANS)};
            else
              w.reg_address = {1'b0, RHYTHM_REG};
            w.is_playing = playing;
            batch.push_back(w);
          end
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last_write = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_write(res_t got);
      res_t want;
      n_writes++;
      if (got.key_valid === 1'b1) n_key_reports++;
      if (pending.size() == 0) begin
        $error("register write 0x%0h = 0x%0h with nothing pending",
               got.reg_address, got.reg_value);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      check_field("reg_address", want.reg_address, got.reg_address);
      check_field("reg_value",   want.reg_value,   got.reg_value);
      check_field("key_valid",   want.key_valid,   got.key_valid);
      check_field("key_code",    want.key_code,    got.key_code);
      check_field("is_playing",  want.is_playing,  got.is_playing);
      check_field("last_write",  want.last_write,  got.last_write);
    endfunction
  endclass

endpackage

// ===== verif/timed_register_write_sequencer_core_test.sv =====
// ---------------------------------------------------------------------------
// timed_register_write_sequencer_core_test
// Loads songs through the request channel, plays them with start, stop, tick
// and silence requests under a range of settings, and checks every register
// write against the scoreboard while both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_register_write_sequencer_core_test;
  import tws_pkg::*;
  import tws_song_check_pkg::*;

  localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
  localparam int SETTLE_CYCLES = 600;
  localparam int STYLE_MIXED   = 0;
  localparam int STYLE_WRITES  = 1;
  localparam int STYLE_DELAYS  = 2;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  tws_in_if  in_ch ();
  tws_out_if out_ch ();

  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int unsigned    n_settings     = 0;
  song_scoreboard sb             = new();

  timed_register_write_sequencer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("[timed_register_write_sequencer_core] ERROR");
    $finish;
  end

  // write side: take a transaction whenever valid and ready meet, then stall at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_write({out_ch.reg_address, out_ch.reg_value, out_ch.key_valid,
                        out_ch.key_code, out_ch.is_playing, out_ch.last_write});
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send(input logic [2:0] req, input logic [13:0] addr,
                      input logic [7:0] data, input logic [15:0] ms);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= req;
    in_ch.load_address <= addr;
    in_ch.load_byte    <= data;
    in_ch.elapsed_ms   <= ms;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(req, addr, data, ms);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // a tick may still be walking delays with no write left to show for it
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  function automatic logic [15:0] tick_ms();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 18) return 16'($urandom_range(65535, 30000));
    return 16'($urandom_range(40, 1));
  endfunction

  // mostly key-on registers and the rhythm register so key reports show up
  function automatic logic [7:0] table_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'(KEY_LO + $urandom_range(KEY_CHANS - 1));
    if (r < 55) return RHYTHM_REG;
    return 8'($urandom_range(255));
  endfunction

  task automatic make_pair(input int style, output logic [7:0] code, output logic [7:0] val);
    int r;
    r   = $urandom_range(99);
    val = 8'($urandom_range(255));
    if (style == STYLE_DELAYS) begin
      if (r < 88) begin
        code = sb.short_dly;
        val  = 8'($urandom_range(3));
        return;
      end
    end else if (style == STYLE_MIXED) begin
      if (r < 22) begin
        code = sb.short_dly;
        val  = 8'($urandom_range(15));
        return;
      end else if (r < 30) begin
        code = sb.long_dly;
        val  = 8'($urandom_range(1));
        return;
      end else if (r < 31) begin
        code = sb.long_dly;
        val  = 8'hFF;
        return;
      end else if (r < 33) begin
        code = sb.short_dly;
        val  = 8'hFF;
        return;
      end
    end
    do code = 8'($urandom_range(255));
    while (code == sb.short_dly || code == sb.long_dly);
  endtask

  task automatic run_phase(input logic [7:0] short_c, input logic [7:0] long_c,
                           input int unsigned tl, input int unsigned sl,
                           input bit loop_e, input bit key_e, input int style,
                           input int n_rand, input bit restart, input bit new_table);
    int unsigned lo;
    int unsigned hi;
    int unsigned pos;
    logic [7:0]  code;
    logic [7:0]  val;
    int          r;
    settle();
    n_settings++;
    cfg_write(CFG_SHORT_DELAY, short_c);
    cfg_write(CFG_LONG_DELAY, long_c);
    cfg_write(CFG_TABLE_LEN, tl);
    cfg_write(CFG_SONG_LEN, sl);
    cfg_write(CFG_LOOP, loop_e);
    cfg_write(CFG_KEY_REPORT, key_e);
    for (pos = 0; pos < TABLE_SPAN; pos++)
      if (new_table || !sb.loaded[pos])
        send(REQ_LOAD, pos, table_byte(), tick_ms());
    hi = (sl + 1 < MEM_BYTES) ? sl + 1 : MEM_BYTES;
    lo = (restart || sb.rd_pos > tl) ? tl : sb.rd_pos;
    // without a restart the walk resumes from where the last song left it
    for (pos = lo; pos < tl && pos < hi; pos++)
      if (!sb.loaded[pos]) send(REQ_LOAD, pos, 8'($urandom_range(255)), tick_ms());
    for (pos = tl; pos < hi; pos += 2) begin
      make_pair(style, code, val);
      send(REQ_LOAD, pos, code, tick_ms());
      if (pos + 1 < hi) send(REQ_LOAD, pos + 1, val, tick_ms());
    end
    if (restart) send(REQ_START, 14'($urandom_range(16383)), 8'($urandom_range(255)), tick_ms());
    for (int i = 0; i < n_rand; i++) begin
      if (i == n_rand / 2) drain();
      r = $urandom_range(99);
      if (r < 58) begin
        send(REQ_TICK, 14'($urandom_range(16383)), 8'($urandom_range(255)), tick_ms());
      end else if (r < 72 && hi > tl) begin
        pos = tl + $urandom_range(hi - tl - 1);
        make_pair(style, code, val);
        send(REQ_LOAD, pos, ((pos - tl) % 2 == 0) ? code : val, tick_ms());
      end else if (r < 77) begin
        send(REQ_LOAD, 14'($urandom_range(16383)), 8'($urandom_range(255)), tick_ms());
      end else if (r < 84) begin
        send(REQ_START, 14'($urandom_range(16383)), 8'($urandom_range(255)), tick_ms());
      end else if (r < 89) begin
        send(REQ_STOP, 14'($urandom_range(16383)), 8'($urandom_range(255)), tick_ms());
      end else if (r < 95) begin
        send(REQ_SILENCE, 14'($urandom_range(16383)), 8'($urandom_range(255)), tick_ms());
      end else begin
        send(3'(REQ_RESERVED_LO + $urandom_range(2)), 14'($urandom_range(16383)),
             8'($urandom_range(255)), tick_ms());
      end
    end
  endtask

  task automatic random_phase(input int n_rand);
    logic [7:0]  short_c;
    logic [7:0]  long_c;
    int unsigned tl;
    short_c = 8'($urandom_range(255));
    long_c  = ($urandom_range(9) == 0) ? short_c : 8'($urandom_range(255));
    tl      = ($urandom_range(4) == 0) ? $urandom_range(16000, 128) : $urandom_range(127);
    run_phase(short_c, long_c, tl, tl + $urandom_range(24, 2), $urandom_range(3) != 0,
              1'($urandom_range(1)), STYLE_MIXED, n_rand, 1'b1, 1'b0);
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_LOAD;
    in_ch.load_address <= '0;
    in_ch.load_byte    <= '0;
    in_ch.elapsed_ms   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 19;
    recv_stall_pct = 53;
    // out of reset: nothing loaded, every setting zero
    send(REQ_TICK, 14'h3FFF, 8'hFF, 16'hFFFF);
    send(REQ_SILENCE, 14'h0000, 8'h00, 16'h0000);
    send(REQ_START, 14'h2AAA, 8'h55, 16'h5555);
    send(REQ_TICK, 14'h1555, 8'hAA, 16'h0000);
    send(REQ_STOP, 14'h0000, 8'h00, 16'hAAAA);
    send(REQ_RESERVED_LO, 14'h0000, 8'h00, 16'h0000);
    send(3'(REQ_RESERVED_LO + 1), 14'h3FFF, 8'hFF, 16'hFFFF);
    send(3'(REQ_RESERVED_LO + 2), 14'h0000, 8'h00, 16'h0001);
    send(REQ_LOAD, 14'h3FFF, 8'hFF, 16'h0000);
    send(REQ_LOAD, 14'h0000, 8'h00, 16'hFFFF);

    // both delay codes the same, odd song tail, table at the stream start
    run_phase(8'h00, 8'h00, 0, 21, 1'b1, 1'b1, STYLE_MIXED, 14, 1'b1, 1'b1);
    // register writes only: every tick runs into the write cap
    run_phase(8'h10, 8'h11, 128, 140, 1'b1, 1'b1, STYLE_WRITES, 10, 1'b1, 1'b0);
    // mostly short delays under random elapsed times
    run_phase(8'hFF, 8'hFE, 130, 150, 1'b1, 1'b0, STYLE_DELAYS, 10, 1'b1, 1'b0);
    send(REQ_START, 14'h0000, 8'h00, 16'h0000);
    // song shrunk below its table while playing: empty looping song
    run_phase(8'hFF, 8'h00, 300, 160, 1'b1, 1'b1, STYLE_MIXED, 6, 1'b0, 1'b0);

    send_idle_pct  = 53;
    recv_stall_pct = 19;
    // last pair reads past the end of memory, no loop at the end
    run_phase(8'h01, 8'h02, 16361, 16384, 1'b0, 1'b1, STYLE_MIXED, 12, 1'b1, 1'b0);
    // table length equal to the song length: start never begins playback
    run_phase(8'h80, 8'h81, 16384, 16384, 1'b1, 1'b0, STYLE_MIXED, 6, 1'b1, 1'b0);
    random_phase(20);
    random_phase(20);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(20);
    random_phase(20);
    random_phase(20);

    settle();
    $display("covered %0d requests (%0d ticks) under %0d settings", sb.n_items,
             sb.n_ticks, n_settings);
    $display("checked %0d register writes, %0d of them with key reports", sb.n_writes,
             sb.n_key_reports);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("[timed_register_write_sequencer_core] OK");
    end else begin
      $display("[timed_register_write_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule
